FILE: sv/sitda_pkg.sv
package sitda_pkg;

    localparam int MAG_BITS   = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_BITS   = BCD_DIGITS * 4;
    localparam int STEP_BITS  = $clog2(MAG_BITS);
    localparam int NDIG_BITS  = $clog2(BCD_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef logic [MAG_BITS-1:0] mag_t;
    typedef logic [BCD_BITS-1:0] bcd_t;
    typedef logic [3:0]          digit_t;

    typedef struct packed {
        logic load;
        mag_t mag;
    } dab_cmd_t;

    typedef struct packed {
        logic done;
        bcd_t bcd;
    } dab_stat_t;

endpackage

FILE: sv/sitda_dabble.sv
module sitda_dabble
(
    input  logic                clk,
    input  logic                rst_n,
    input  sitda_pkg::dab_cmd_t cmd,
    output sitda_pkg::dab_stat_t stat
);
    import sitda_pkg::*;

    mag_t                 bin_reg, bin_next;
    bcd_t                 bcd_reg, bcd_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    bcd_t                 bcd_adj;

    // add-3 on every digit of 5 or more, then shift one bit in
    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] >= 4'd5)
            begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (cmd.load)
        begin
            bin_next = cmd.mag;
            bcd_next = '0;
            cnt_next = STEP_BITS'(MAG_BITS - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next = {bcd_adj[BCD_BITS-2:0], bin_reg[MAG_BITS-1]};
            bin_next = {bin_reg[MAG_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.done = ~run_reg;
    assign stat.bcd  = bcd_reg;

endmodule

FILE: sv/signed_int_to_decimal_ascii.sv
// Converts a signed 32-bit value to its decimal ASCII text, one character per
// valid pulse, most significant first: '-' for negative values, no leading
// zeros, last_char set on the final digit. A value is taken when start is high
// and busy is low; busy then stays high until the last character is issued.
// Per value: acceptance, conversion in the shift/add-3 binary-to-BCD unit,
// capture of its BCD result, stripping of leading zeros one digit at a time
// with at least one digit kept, an optional '-' and then the digits, one
// character at a time. Each character is on text_char and last_char for
// exactly one cycle with valid high; the receiver cannot stall, so every
// character must be captured the cycle it appears.
module signed_int_to_decimal_ascii
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [31:0] value,
    output logic        valid,
    output logic [7:0]  text_char,
    output logic        last_char
);
    import sitda_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_SKIP = 3'd2;
    localparam logic [2:0] S_SIGN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic                 neg_reg, neg_next;
    bcd_t                 dig_reg, dig_next;
    logic [NDIG_BITS-1:0] ndig_reg, ndig_next;
    logic                 valid_reg, valid_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;

    dab_cmd_t  dab_cmd;
    dab_stat_t dab_stat;
    digit_t    top_dig;
    logic      accept;

    sitda_dabble u_dabble
    (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (dab_cmd),
        .stat (dab_stat)
    );

    assign accept      = start && (state_reg == S_IDLE);
    assign dab_cmd.load = accept;
    assign dab_cmd.mag  = value[31] ? mag_t'(-value) : mag_t'(value);
    assign top_dig     = dig_reg[BCD_BITS-1 -: 4];

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        dig_next   = dig_reg;
        ndig_next  = ndig_reg;
        valid_next = 1'b0;
        char_next  = char_reg;
        last_next  = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = value[31];
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (dab_stat.done)
                begin
                    dig_next   = dab_stat.bcd;
                    ndig_next  = NDIG_BITS'(BCD_DIGITS);
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (top_dig == '0 && ndig_reg > NDIG_BITS'(1))
                begin
                    dig_next  = {dig_reg[BCD_BITS-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end
                else if (neg_reg)
                begin
                    state_next = S_SIGN;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SIGN:
            begin
                valid_next = 1'b1;
                char_next  = CHAR_MINUS;
                last_next  = 1'b0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                valid_next = 1'b1;
                char_next  = CHAR_ZERO + {4'd0, top_dig};
                last_next  = (ndig_reg == NDIG_BITS'(1));
                dig_next   = {dig_reg[BCD_BITS-5:0], 4'd0};
                ndig_next  = ndig_reg - 1'b1;
                if (ndig_reg == NDIG_BITS'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        dig_reg  <= dig_next;
        ndig_reg <= ndig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign valid     = valid_reg;
    assign text_char = char_reg;
    assign last_char = last_reg;

endmodule

FILE: test/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

    import sitda_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 97;
    localparam int RADIX        = 10;

    typedef struct {
        logic [7:0] text_char;
        logic       last_char;
    } char_item_t;

    class char_scoreboard;
        char_item_t pending_chars[$];
        int         errors;

        function void note_value(input logic signed [31:0] v);
            logic [32:0] mag;
            digit_t      digits[BCD_DIGITS];
            int          nd;
            char_item_t  c;
            mag = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
            nd  = 0;
            do
            begin
                digits[nd] = digit_t'(mag % RADIX);
                nd++;
                mag = mag / RADIX;
            end
            while (mag != 0 && nd < BCD_DIGITS);
            if (v[31])
            begin
                c.text_char = CHAR_MINUS;
                c.last_char = 1'b0;
                pending_chars.push_back(c);
            end
            for (int i = nd - 1; i >= 0; i--)
            begin
                c.text_char = CHAR_ZERO + {4'd0, digits[i]};
                c.last_char = (i == 0);
                pending_chars.push_back(c);
            end
        endfunction

        function void check_char(input logic [7:0] ch, input logic last);
            char_item_t e;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character transfer: text_char %h last_char %b", ch, last);
                errors++;
                return;
            end
            e = pending_chars.pop_front();
            if (ch !== e.text_char)
            begin
                $error("text_char: expected %h, got %h", e.text_char, ch);
                errors++;
            end
            if (last !== e.last_char)
            begin
                $error("last_char: expected %b, got %b", e.last_char, last);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] value;
    logic               valid;
    logic [7:0]         text_char;
    logic               last_char;

    char_scoreboard board;
    int             stall_cycles;

    signed_int_to_decimal_ascii i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .valid     (valid),
        .text_char (text_char),
        .last_char (last_char)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && valid)
            board.check_char(text_char, last_char);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || valid)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // start is raised at random while waiting, so it also lands while busy is high
    task automatic send_value(input logic signed [31:0] v, input int idle_pct);
        do
        begin
            start <= ($urandom_range(99) >= idle_pct);
            value <= v;
            @(posedge clk);
        end
        while (!(start && !busy));
        board.note_value(v);
    endtask

    function automatic logic signed [31:0] random_value();
        longint unsigned top;
        longint unsigned mag;
        int              nd;
        if ($urandom_range(3) == 0)
            return $urandom;
        nd  = $urandom_range(1, 10);
        top = 1;
        for (int i = 0; i < nd; i++)
            top = top * RADIX;
        if (top > 64'd2147483648)
            top = 64'd2147483648;
        mag = {$urandom, $urandom} % top;
        if ($urandom_range(1))
            return 32'(-mag);
        return 32'(mag);
    endfunction

    initial
    begin
        logic signed [31:0] directed[$];
        int                 idle_pct[3];
        directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                     32'sd100, -32'sd100, 32'sd5, -32'sd5, 32'sd2147483647,
                     32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
                     32'sd999999999, -32'sd999999999, 32'sd1999999999,
                     32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA, 32'sd1000};
        idle_pct = '{29, 57, 0};
        board    = new;
        clk      = 1'b0;
        rst_n    = 1'b0;
        start    = 1'b0;
        value    = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_value(directed[i], idle_pct[0]);
        foreach (idle_pct[p])
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_value(random_value(), idle_pct[p]);
        start <= 1'b0;
        while (board.pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
sv/sitda_pkg.sv
sv/sitda_dabble.sv
sv/signed_int_to_decimal_ascii.sv
test/signed_int_to_decimal_ascii_tb.sv
